[hdl/tews_pkg.sv]
// Shared types and constants of the timed event window scheduler.
// No dependencies; every other file imports this package.
package tews_pkg;

    localparam int STAGING_DEPTH_DEF = 128;
    localparam int OUT_DEPTH_DEF     = 64;

    localparam logic [18:0] SAMPLE_RATE_RST = 19'd48000;
    localparam logic [31:0] EXPIRY_RST      = 32'd262144;
    localparam logic [31:0] TOLERANCE_RST   = 32'd3277;
    localparam logic [6:0]  MAX_OUT_RST     = 7'd64;

    localparam logic [12:0] OFFSET_MAX = 13'd8191;
    localparam logic [2:0]  PRIO_MAX   = 3'd5;
    localparam logic [2:0]  KIND_TOP   = 3'd4;

    typedef enum logic [1:0] {
        MODE_PUSH     = 2'd0,
        MODE_RETRIEVE = 2'd1,
        MODE_CLEAR    = 2'd2,
        MODE_UNUSED   = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        STAT_STORED  = 3'd0,
        STAT_INVALID = 3'd1,
        STAT_FULL    = 3'd2,
        STAT_RESULT  = 3'd3,
        STAT_CLEARED = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        CFG_SAMPLE_RATE = 2'd0,
        CFG_EXPIRY      = 2'd1,
        CFG_TOLERANCE   = 2'd2,
        CFG_MAX_OUT     = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [24:0] rate_mult;
        logic [31:0] expiry;
        logic [31:0] tolerance;
        logic [6:0]  cap;
    } cfg_t;

endpackage

[hdl/tews_cfg.sv]
// Configuration registers of the scheduler and values derived from them.
// Depends on tews_pkg.
module tews_cfg #(
    parameter int OUT_DEPTH = tews_pkg::OUT_DEPTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [31:0]         cfg_data,
    output tews_pkg::cfg_t      cfg
);
    import tews_pkg::*;

    localparam logic [6:0] CAP_MAX = 7'(OUT_DEPTH);

    logic [18:0] rate_reg;
    logic [31:0] expiry_reg;
    logic [31:0] tol_reg;
    logic [6:0]  max_out_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg    <= SAMPLE_RATE_RST;
            expiry_reg  <= EXPIRY_RST;
            tol_reg     <= TOLERANCE_RST;
            max_out_reg <= MAX_OUT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_SAMPLE_RATE: rate_reg    <= cfg_data[18:0];
                CFG_EXPIRY:      expiry_reg  <= cfg_data;
                CFG_TOLERANCE:   tol_reg     <= cfg_data;
                CFG_MAX_OUT:     max_out_reg <= cfg_data[6:0];
                default:         rate_reg    <= rate_reg;
            endcase
        end
    end

    always_comb
    begin
        cfg.rate_mult = {rate_reg, 6'b0} - {4'b0, rate_reg, 2'b0};
        cfg.expiry    = expiry_reg;
        cfg.tolerance = tol_reg;
        cfg.cap       = (max_out_reg > CAP_MAX) ? CAP_MAX : max_out_reg;
    end

endmodule

[hdl/tews_offset.sv]
// Sample offset unit: shared multiplier over two partial products, then a
// restoring divider one quotient bit per cycle. Depends on tews_pkg.
module tews_offset (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        go,
    input  logic [46:0] diff,
    input  logic [24:0] rate_mult,
    input  logic [25:0] tempo,
    input  logic [13:0] num_samples,
    output logic        done,
    output logic [12:0] offset
);
    import tews_pkg::*;

    typedef enum logic [5:0] {
        O_IDLE = 6'b000001,
        O_LO   = 6'b000010,
        O_HI   = 6'b000100,
        O_PREP = 6'b001000,
        O_DIV  = 6'b010000,
        O_FIN  = 6'b100000
    } ostate_t;

    ostate_t     ost_reg, ost_next;
    logic [71:0] acc_reg, acc_next;
    logic [73:0] rem_reg, rem_next;
    logic [13:0] q_reg, q_next;
    logic [3:0]  b_reg, b_next;
    logic        sat_reg, sat_next;
    logic        done_reg, done_next;
    logic [12:0] off_reg, off_next;

    logic [23:0] mul_a;
    logic [48:0] prod;
    logic [73:0] dsh;
    logic [13:0] hi_wide;
    logic [13:0] hi;

    assign mul_a   = (ost_reg == O_HI) ? {1'b0, diff[46:24]} : diff[23:0];
    assign prod    = {25'b0, mul_a} * {24'b0, rate_mult};
    assign dsh     = {47'b0, tempo, 1'b0} << b_reg;
    assign hi_wide = num_samples - 14'd1;
    assign hi      = (hi_wide > {1'b0, OFFSET_MAX}) ? {1'b0, OFFSET_MAX} : hi_wide;
    assign done    = done_reg;
    assign offset  = off_reg;

    always_comb
    begin
        ost_next  = ost_reg;
        acc_next  = acc_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        b_next    = b_reg;
        sat_next  = sat_reg;
        done_next = 1'b0;
        off_next  = off_reg;
        case (ost_reg)
            O_IDLE:
            begin
                if (go)
                    ost_next = O_LO;
            end
            O_LO:
            begin
                if (num_samples == 14'd0 || rate_mult == 25'd0 || diff == 47'd0)
                begin
                    off_next  = 13'd0;
                    done_next = 1'b1;
                    ost_next  = O_IDLE;
                end
                else
                begin
                    acc_next = {23'b0, prod};
                    ost_next = O_HI;
                end
            end
            O_HI:
            begin
                acc_next = acc_reg + {prod[47:0], 24'b0};
                ost_next = O_PREP;
            end
            O_PREP:
            begin
                rem_next = {1'b0, acc_reg, 1'b0} + {48'b0, tempo};
                b_next   = 4'd14;
                q_next   = 14'd0;
                sat_next = 1'b0;
                ost_next = O_DIV;
            end
            O_DIV:
            begin
                if (rem_reg >= dsh)
                begin
                    rem_next = rem_reg - dsh;
                    if (b_reg == 4'd14)
                        sat_next = 1'b1;
                    else
                        q_next[b_reg] = 1'b1;
                end
                if (b_reg == 4'd0)
                    ost_next = O_FIN;
                else
                    b_next = b_reg - 4'd1;
            end
            O_FIN:
            begin
                off_next  = (sat_reg || q_reg > hi) ? hi[12:0] : q_reg[12:0];
                done_next = 1'b1;
                ost_next  = O_IDLE;
            end
            default:
            begin
                ost_next = O_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ost_reg  <= O_IDLE;
            done_reg <= 1'b0;
        end
        else
        begin
            ost_reg  <= ost_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        rem_reg <= rem_next;
        q_reg   <= q_next;
        b_reg   <= b_next;
        sat_reg <= sat_next;
        off_reg <= off_next;
    end

endmodule

[hdl/timed_event_window_scheduler.sv]
// Timed event window scheduler, top level: staging table, sort buffer and
// the sequencer that walks them. Depends on tews_pkg, tews_cfg, tews_offset.
//
// Usage: an item is taken when start is high and busy is low; mode selects
// push, retrieve or clear. Every result is shown for one cycle with
// result_valid high; last marks the final result of the item. Registers are
// written through cfg_valid/cfg_ready/cfg_index/cfg_data, cfg_ready is always
// high, and writes belong to idle periods.
// Push, clear and the unused mode answer in the cycle after the transfer and
// the block is free again at once.
// Retrieve walks the staging table top down through its single read port:
// each entry is read and judged; a removed entry's slot is refilled from
// the last entry, an in-window match waits for the multiply and 15-step
// divide of the offset unit (cut short when the offset is trivially zero),
// each match is placed by an insertion sort moving larger buffered matches
// up, then results or an empty answer go out. busy stays high meanwhile.
// Reset empties the staging table and loads register defaults; the receiver
// cannot hold results off, so no result ever waits.
module timed_event_window_scheduler #(
    parameter int STAGING_DEPTH = tews_pkg::STAGING_DEPTH_DEF,
    parameter int OUT_DEPTH     = tews_pkg::OUT_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         mode,
    input  logic signed [47:0] beat_time,
    input  logic [15:0]        target,
    input  logic [2:0]         event_kind,
    input  logic [3:0]         chan,
    input  logic [15:0]        data_one,
    input  logic [15:0]        data_two,
    input  logic [31:0]        float_word,
    input  logic [46:0]        block_start,
    input  logic [46:0]        block_end,
    input  logic [13:0]        num_samples,
    input  logic [25:0]        tempo,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    output logic               result_valid,
    output logic [2:0]         status,
    output logic               has_event,
    output logic [12:0]        sample_offset,
    output logic [15:0]        out_target,
    output logic [2:0]         out_kind,
    output logic [3:0]         out_chan,
    output logic [15:0]        out_data_one,
    output logic [15:0]        out_data_two,
    output logic [31:0]        out_float_word,
    output logic [6:0]         emitted_count,
    output logic               last
);
    import tews_pkg::*;

    localparam int SW = $clog2(STAGING_DEPTH);
    localparam int CW = $clog2(STAGING_DEPTH + 1);
    localparam int OW = (OUT_DEPTH > 1) ? $clog2(OUT_DEPTH) : 1;
    localparam int NW = $clog2(OUT_DEPTH + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(STAGING_DEPTH);

    typedef struct packed {
        logic [3:0]  chan;
        logic [2:0]  kind;
        logic [15:0] target;
    } meta_t;

    typedef struct packed {
        logic [46:0] beat;
        meta_t       meta;
        logic [31:0] data;
        logic [31:0] value;
    } stage_t;

    typedef struct packed {
        logic [15:0] key;
        meta_t       meta;
        logic [31:0] data;
        logic [31:0] value;
    } sort_t;

    typedef struct packed {
        logic [2:0]  status;
        logic        has;
        logic [12:0] offset;
        meta_t       meta;
        logic [31:0] data;
        logic [31:0] value;
        logic [6:0]  count;
        logic        last;
    } res_t;

    typedef enum logic [10:0] {
        S_IDLE    = 11'b00000000001,
        S_SCAN_RD = 11'b00000000010,
        S_SCAN_EV = 11'b00000000100,
        S_CALC    = 11'b00000001000,
        S_INS_RD  = 11'b00000010000,
        S_INS_CMP = 11'b00000100000,
        S_REMOVE  = 11'b00001000000,
        S_MOVE_WR = 11'b00010000000,
        S_OUT_RD  = 11'b00100000000,
        S_OUT_EM  = 11'b01000000000,
        S_SPARE   = 11'b10000000000
    } state_t;

    cfg_t cfg;

    state_t        state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] left_reg, left_next;
    logic [NW-1:0] n_reg, n_next;
    logic [NW-1:0] ins_reg, ins_next;
    logic [NW-1:0] k_reg, k_next;
    logic          rv_reg, rv_next;
    res_t          res_reg, res_next;
    logic [46:0]   bstart_reg, bstart_next;
    logic [46:0]   bend_reg, bend_next;
    logic [13:0]   ns_reg, ns_next;
    logic [25:0]   tempo_reg, tempo_next;
    logic [15:0]   key_reg, key_next;
    logic [46:0]   diff_reg, diff_next;

    stage_t stage_mem [STAGING_DEPTH];
    stage_t st_q;
    logic   st_we, st_re;
    logic [SW-1:0] st_waddr, st_raddr;
    stage_t st_wdata;

    sort_t  sort_mem [OUT_DEPTH];
    sort_t  so_q;
    logic   so_we, so_re;
    logic [OW-1:0] so_waddr, so_raddr;
    sort_t  so_wdata;

    logic          off_go;
    logic          off_done;
    logic [12:0]   off_val;

    logic          accept;
    logic [CW-1:0] cur_wide;
    logic [SW-1:0] cur_idx;
    logic [CW-1:0] last_wide;
    logic [48:0]   ahead;
    logic [48:0]   expiry_sum;
    logic [46:0]   lateness;
    logic          expired, in_win, late_ok;
    logic [2:0]    prio;
    logic [NW-1:0] ins_m1;
    logic [NW-1:0] n_m1;
    sort_t         new_item;
    res_t          empty_res;

    tews_cfg #(
        .OUT_DEPTH(OUT_DEPTH)
    ) u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .cfg      (cfg)
    );

    tews_offset u_offset (
        .clk        (clk),
        .rst_n      (rst_n),
        .go         (off_go),
        .diff       (diff_reg),
        .rate_mult  (cfg.rate_mult),
        .tempo      (tempo_reg),
        .num_samples(ns_reg),
        .done       (off_done),
        .offset     (off_val)
    );

    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;

    assign cur_wide   = left_reg - CW'(1);
    assign cur_idx    = cur_wide[SW-1:0];
    assign last_wide  = count_reg - CW'(1);
    assign ahead      = {2'b0, st_q.beat} - {2'b0, bstart_reg};
    assign expiry_sum = ahead + {17'b0, cfg.expiry};
    assign expired    = expiry_sum[48];
    assign in_win     = (st_q.beat >= bstart_reg) && (st_q.beat < bend_reg);
    assign lateness   = bstart_reg - st_q.beat;
    assign late_ok    = ahead[48] && (lateness <= {15'b0, cfg.tolerance});
    assign prio       = (st_q.meta.kind > KIND_TOP) ? PRIO_MAX : st_q.meta.kind;
    assign ins_m1     = ins_reg - NW'(1);
    assign n_m1       = n_reg - NW'(1);

    always_comb
    begin
        new_item.key   = key_reg;
        new_item.meta  = st_q.meta;
        new_item.data  = st_q.data;
        new_item.value = st_q.value;
        empty_res        = '0;
        empty_res.status = STAT_RESULT;
        empty_res.last   = 1'b1;
    end

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        left_next   = left_reg;
        n_next      = n_reg;
        ins_next    = ins_reg;
        k_next      = k_reg;
        rv_next     = 1'b0;
        res_next    = res_reg;
        bstart_next = bstart_reg;
        bend_next   = bend_reg;
        ns_next     = ns_reg;
        tempo_next  = tempo_reg;
        key_next    = key_reg;
        diff_next   = diff_reg;
        off_go      = 1'b0;
        st_we       = 1'b0;
        st_waddr    = count_reg[SW-1:0];
        st_wdata    = st_q;
        st_re       = 1'b0;
        st_raddr    = cur_idx;
        so_we       = 1'b0;
        so_waddr    = ins_reg[OW-1:0];
        so_wdata    = new_item;
        so_re       = 1'b0;
        so_raddr    = ins_m1[OW-1:0];
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    res_next      = '0;
                    res_next.last = 1'b1;
                    rv_next       = 1'b1;
                    case (mode_t'(mode))
                        MODE_PUSH:
                        begin
                            if (beat_time[47])
                                res_next.status = STAT_INVALID;
                            else if (count_reg >= FULL_COUNT)
                                res_next.status = STAT_FULL;
                            else
                            begin
                                res_next.status = STAT_STORED;
                                st_we            = 1'b1;
                                st_wdata.beat    = beat_time[46:0];
                                st_wdata.meta    = {chan, event_kind, target};
                                st_wdata.data    = {data_two, data_one};
                                st_wdata.value   = float_word;
                                count_next       = count_reg + CW'(1);
                            end
                        end
                        MODE_CLEAR:
                        begin
                            res_next.status = STAT_CLEARED;
                            count_next      = '0;
                        end
                        MODE_RETRIEVE:
                        begin
                            rv_next     = 1'b0;
                            bstart_next = block_start;
                            bend_next   = block_end;
                            ns_next     = num_samples;
                            tempo_next  = tempo;
                            left_next   = count_reg;
                            n_next      = '0;
                            state_next  = S_SCAN_RD;
                        end
                        default:
                        begin
                            res_next.status = STAT_INVALID;
                        end
                    endcase
                end
            end
            S_SCAN_RD:
            begin
                if (left_reg == '0)
                begin
                    if (n_reg == '0)
                    begin
                        rv_next    = 1'b1;
                        res_next   = empty_res;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        k_next     = '0;
                        state_next = S_OUT_RD;
                    end
                end
                else
                begin
                    st_re      = 1'b1;
                    state_next = S_SCAN_EV;
                end
            end
            S_SCAN_EV:
            begin
                if (expired)
                    state_next = S_REMOVE;
                else if ((in_win || late_ok) && (7'(n_reg) < cfg.cap))
                begin
                    ins_next = n_reg;
                    if (in_win)
                    begin
                        off_go     = 1'b1;
                        diff_next  = ahead[46:0];
                        state_next = S_CALC;
                    end
                    else
                    begin
                        key_next   = {13'b0, prio};
                        state_next = S_INS_RD;
                    end
                end
                else
                begin
                    left_next  = left_reg - CW'(1);
                    state_next = S_SCAN_RD;
                end
            end
            S_CALC:
            begin
                if (off_done)
                begin
                    key_next   = {off_val, prio};
                    state_next = S_INS_RD;
                end
            end
            S_INS_RD:
            begin
                if (ins_reg == '0)
                begin
                    so_we      = 1'b1;
                    n_next     = n_reg + NW'(1);
                    state_next = S_REMOVE;
                end
                else
                begin
                    so_re      = 1'b1;
                    state_next = S_INS_CMP;
                end
            end
            S_INS_CMP:
            begin
                so_we = 1'b1;
                if (so_q.key > key_reg)
                begin
                    so_wdata   = so_q;
                    ins_next   = ins_m1;
                    state_next = S_INS_RD;
                end
                else
                begin
                    n_next     = n_reg + NW'(1);
                    state_next = S_REMOVE;
                end
            end
            S_REMOVE:
            begin
                count_next = last_wide;
                if (last_wide == cur_wide)
                begin
                    left_next  = left_reg - CW'(1);
                    state_next = S_SCAN_RD;
                end
                else
                begin
                    st_re      = 1'b1;
                    st_raddr   = last_wide[SW-1:0];
                    state_next = S_MOVE_WR;
                end
            end
            S_MOVE_WR:
            begin
                st_we      = 1'b1;
                st_waddr   = cur_idx;
                left_next  = left_reg - CW'(1);
                state_next = S_SCAN_RD;
            end
            S_OUT_RD:
            begin
                so_re      = 1'b1;
                so_raddr   = k_reg[OW-1:0];
                state_next = S_OUT_EM;
            end
            S_OUT_EM:
            begin
                rv_next         = 1'b1;
                res_next.status = STAT_RESULT;
                res_next.has    = 1'b1;
                res_next.offset = so_q.key[15:3];
                res_next.meta   = so_q.meta;
                res_next.data   = so_q.data;
                res_next.value  = so_q.value;
                res_next.count  = 7'(n_reg);
                res_next.last   = (k_reg == n_m1);
                k_next          = k_reg + NW'(1);
                state_next      = (k_reg == n_m1) ? S_IDLE : S_OUT_RD;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            left_reg  <= '0;
            n_reg     <= '0;
            ins_reg   <= '0;
            k_reg     <= '0;
            rv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            left_reg  <= left_next;
            n_reg     <= n_next;
            ins_reg   <= ins_next;
            k_reg     <= k_next;
            rv_reg    <= rv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg    <= res_next;
        bstart_reg <= bstart_next;
        bend_reg   <= bend_next;
        ns_reg     <= ns_next;
        tempo_reg  <= tempo_next;
        key_reg    <= key_next;
        diff_reg   <= diff_next;
    end

    always_ff @(posedge clk)
    begin
        if (st_we)
            stage_mem[st_waddr] <= st_wdata;
        if (st_re)
            st_q <= stage_mem[st_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (so_we)
            sort_mem[so_waddr] <= so_wdata;
        if (so_re)
            so_q <= sort_mem[so_raddr];
    end

    assign result_valid   = rv_reg;
    assign status         = res_reg.status;
    assign has_event      = res_reg.has;
    assign sample_offset  = res_reg.offset;
    assign out_target     = res_reg.meta.target;
    assign out_kind       = res_reg.meta.kind;
    assign out_chan       = res_reg.meta.chan;
    assign out_data_one   = res_reg.data[15:0];
    assign out_data_two   = res_reg.data[31:16];
    assign out_float_word = res_reg.value;
    assign emitted_count  = res_reg.count;
    assign last           = res_reg.last;

endmodule

[hdl/tews_chk.sv]
// Port-level checks of the scheduler, attached to the top level by bind.
// Depends on tews_pkg and timed_event_window_scheduler.
module tews_chk (
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic [1:0] mode,
    input logic       result_valid,
    input logic [2:0] status,
    input logic       has_event,
    input logic       last
);
    import tews_pkg::*;

    a_short_reply: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && mode != MODE_RETRIEVE |=> result_valid && last)
        else $error("push, clear or unused mode not answered next cycle");

    a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !has_event |-> last)
        else $error("result without event is not last");

    a_event_status: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && has_event |-> status == STAT_RESULT)
        else $error("event result carries wrong status");

    a_more_follows: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !last |=> busy)
        else $error("block idle while results remain");

endmodule

bind timed_event_window_scheduler tews_chk u_tews_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .mode        (mode),
    .result_valid(result_valid),
    .status      (status),
    .has_event   (has_event),
    .last        (last)
);
